>>> rtl/bgp_path_attribute_parser_top_assert.svh
// Assertion macros shared by the checker of the path-attribute parser.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef BGP_PATH_ATTRIBUTE_PARSER_TOP_ASSERT_SVH
`define BGP_PATH_ATTRIBUTE_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BGPAP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BGPAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bgpap_pkg.sv
// Shared types and constants of the BGP path-attribute parser.
// Depends on nothing; used by every RTL module of the block.
`default_nettype none

package bgpap_pkg;

    // Result status codes.
    typedef enum logic [3:0] {
        STAT_OK          = 4'd0,
        STAT_ORIGIN_FLAG = 4'd1,
        STAT_ORIGIN_LEN  = 4'd2,
        STAT_ORIGIN_VAL  = 4'd3,
        STAT_DUP_ASPATH  = 4'd4,
        STAT_NEXTHOP_LEN = 4'd5,
        STAT_MED_LEN     = 4'd6,
        STAT_ATOMIC_LEN  = 4'd7,
        STAT_TRUNCATED   = 4'd8
    } t_status;

    // Attribute type codes.
    localparam logic [7:0] TYPE_ORIGIN    = 8'd1;
    localparam logic [7:0] TYPE_ASPATH    = 8'd2;
    localparam logic [7:0] TYPE_NEXTHOP   = 8'd3;
    localparam logic [7:0] TYPE_MED       = 8'd4;
    localparam logic [7:0] TYPE_LPREF     = 8'd5;
    localparam logic [7:0] TYPE_ATOMIC    = 8'd6;
    localparam logic [7:0] TYPE_COMMUNITY = 8'd8;

    // Attribute flag fields.
    localparam logic [7:0] FLAG_EXTLEN     = 8'h10;
    localparam logic [7:0] FLAG_CLASS_MASK = 8'hE0;
    localparam logic [7:0] FLAG_TRANSITIVE = 8'h40;

    localparam logic [7:0]  ORIGIN_MAX  = 8'd2;
    localparam logic [15:0] LEN_ORIGIN  = 16'd1;
    localparam logic [15:0] LEN_WORD    = 16'd4;

    // One byte after classification by the front end.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ext_len;
        logic       class_ok;
        logic       origin_bad;
    } t_item;

    // One result as produced by the back end.
    typedef struct packed {
        t_status     status;
        logic [1:0]  origin_code;
        logic [31:0] next_hop_addr;
        logic [31:0] med_value;
        logic [31:0] local_pref_value;
        logic        atomic_seen;
        logic        aspath_seen;
        logic        community_seen;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/bgpap_front.sv
// Front end of the parser: classifies each incoming byte before it is queued.
// Depends on bgpap_pkg for the item type and the flag constants.
`default_nettype none

module bgpap_front (
    input  wire logic           i_data_byte_valid,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_last_byte,
    input  wire logic           i_queue_ready,
    output bgpap_pkg::t_item    o_item,
    output logic                o_push,
    output logic                o_in_ready
);

    // The same byte may be a flag byte or an origin value; the back end picks
    // whichever precomputed view its parse phase needs.
    always_comb begin
        o_item.data       = i_data_byte;
        o_item.last       = i_last_byte;
        o_item.ext_len    = (i_data_byte & bgpap_pkg::FLAG_EXTLEN) != 8'd0;
        o_item.class_ok   = (i_data_byte & bgpap_pkg::FLAG_CLASS_MASK)
                            == bgpap_pkg::FLAG_TRANSITIVE;
        o_item.origin_bad = i_data_byte > bgpap_pkg::ORIGIN_MAX;
    end

    assign o_in_ready = i_queue_ready;
    assign o_push     = i_data_byte_valid & i_queue_ready;

endmodule

`default_nettype wire

>>> rtl/bgpap_queue.sv
// Short register queue that decouples the front end from the back end.
// Depends on bgpap_pkg for the queued item type.
`default_nettype none

module bgpap_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire bgpap_pkg::t_item  i_item,
    output logic                   o_not_full,
    input  wire logic              i_pop,
    output logic                   o_not_empty,
    output bgpap_pkg::t_item       o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bgpap_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;

    assign o_not_full  = r_count != CW'(DEPTH);
    assign o_not_empty = r_count != CW'(0);
    assign o_item      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? PW'(0) : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? PW'(0) : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bgpap_back.sv
// Back end of the parser: attribute state machine, capture registers and the
// registered result. Depends on bgpap_pkg for types, codes and constants.
`default_nettype none

module bgpap_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_item_valid,
    input  wire bgpap_pkg::t_item  i_item,
    output logic                   o_pop,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output bgpap_pkg::t_result     o_res
);

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_TYPE,
        PH_LENHI,
        PH_LENLO,
        PH_VALUE,
        PH_DRAIN
    } t_phase;

    t_phase             r_phase,  n_phase;
    logic               r_ext,    n_ext;
    logic               r_cls,    n_cls;
    logic [7:0]         r_type,   n_type;
    logic [15:0]        r_len,    n_len;
    logic [15:0]        r_cnt,    n_cnt;
    logic [31:0]        r_shift,  n_shift;
    logic [1:0]         r_origin, n_origin;
    logic [31:0]        r_nhop,   n_nhop;
    logic [31:0]        r_med,    n_med;
    logic [31:0]        r_lpref,  n_lpref;
    logic               r_atomic, n_atomic;
    logic               r_aspath, n_aspath;
    logic               r_comm,   n_comm;
    logic               r_out_valid;
    bgpap_pkg::t_result r_res;

    bgpap_pkg::t_status err;
    logic               emit;
    logic [15:0]        len_full;
    bgpap_pkg::t_result res;

    assign o_pop       = i_item_valid & (~r_out_valid | i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;
    assign len_full    = {r_len[15:8], i_item.data};

    always_comb begin
        n_phase  = r_phase;
        n_ext    = r_ext;
        n_cls    = r_cls;
        n_type   = r_type;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_origin = r_origin;
        n_nhop   = r_nhop;
        n_med    = r_med;
        n_lpref  = r_lpref;
        n_atomic = r_atomic;
        n_aspath = r_aspath;
        n_comm   = r_comm;
        err      = bgpap_pkg::STAT_OK;
        emit     = 1'b0;
        res      = r_res;

        if (o_pop) begin
            unique case (r_phase)
                PH_FLAG: begin
                    n_ext   = i_item.ext_len;
                    n_cls   = i_item.class_ok;
                    n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type  = i_item.data;
                    n_len   = 16'd0;
                    n_phase = r_ext ? PH_LENHI : PH_LENLO;
                end
                PH_LENHI: begin
                    n_len   = {i_item.data, 8'd0};
                    n_phase = PH_LENLO;
                end
                PH_LENLO: begin
                    n_len   = len_full;
                    n_cnt   = 16'd0;
                    n_shift = 32'd0;
                    unique case (r_type)
                        bgpap_pkg::TYPE_ORIGIN: begin
                            if (!r_cls) begin
                                err = bgpap_pkg::STAT_ORIGIN_FLAG;
                            end else if (len_full != bgpap_pkg::LEN_ORIGIN) begin
                                err = bgpap_pkg::STAT_ORIGIN_LEN;
                            end
                        end
                        bgpap_pkg::TYPE_ASPATH: begin
                            if (r_aspath) begin
                                err = bgpap_pkg::STAT_DUP_ASPATH;
                            end else begin
                                n_aspath = 1'b1;
                            end
                        end
                        bgpap_pkg::TYPE_NEXTHOP: begin
                            if (len_full != bgpap_pkg::LEN_WORD) begin
                                err = bgpap_pkg::STAT_NEXTHOP_LEN;
                            end
                        end
                        bgpap_pkg::TYPE_MED: begin
                            if (len_full != bgpap_pkg::LEN_WORD) begin
                                err = bgpap_pkg::STAT_MED_LEN;
                            end
                        end
                        bgpap_pkg::TYPE_LPREF: begin
                            if (len_full != bgpap_pkg::LEN_WORD) begin
                                n_lpref = 32'd0;
                            end
                        end
                        bgpap_pkg::TYPE_ATOMIC: begin
                            if (len_full != 16'd0) begin
                                err = bgpap_pkg::STAT_ATOMIC_LEN;
                            end else begin
                                n_atomic = 1'b1;
                            end
                        end
                        bgpap_pkg::TYPE_COMMUNITY: begin
                            n_comm = len_full != 16'd0;
                        end
                        default: begin
                        end
                    endcase
                    if (err == bgpap_pkg::STAT_OK) begin
                        n_phase = (len_full != 16'd0) ? PH_VALUE : PH_FLAG;
                    end
                end
                PH_VALUE: begin
                    n_shift = {r_shift[23:0], i_item.data};
                    n_cnt   = r_cnt + 16'd1;
                    if (r_type == bgpap_pkg::TYPE_ORIGIN) begin
                        if (i_item.origin_bad) begin
                            err = bgpap_pkg::STAT_ORIGIN_VAL;
                        end else begin
                            n_origin = i_item.data[1:0];
                        end
                    end
                    if (err == bgpap_pkg::STAT_OK && n_cnt == r_len) begin
                        if (r_type == bgpap_pkg::TYPE_NEXTHOP) begin
                            n_nhop = n_shift;
                        end else if (r_type == bgpap_pkg::TYPE_MED) begin
                            n_med = n_shift;
                        end else if (r_type == bgpap_pkg::TYPE_LPREF
                                     && r_len == bgpap_pkg::LEN_WORD) begin
                            n_lpref = n_shift;
                        end
                        n_phase = PH_FLAG;
                    end
                end
                PH_DRAIN: begin
                end
                default: begin
                    n_phase = PH_FLAG;
                end
            endcase

            if (r_phase != PH_DRAIN) begin
                emit = (err != bgpap_pkg::STAT_OK) | i_item.last;
                res.status           = (err != bgpap_pkg::STAT_OK) ? err :
                                       ((n_phase == PH_FLAG) ? bgpap_pkg::STAT_OK
                                                             : bgpap_pkg::STAT_TRUNCATED);
                res.origin_code      = n_origin;
                res.next_hop_addr    = n_nhop;
                res.med_value        = n_med;
                res.local_pref_value = n_lpref;
                res.atomic_seen      = n_atomic;
                res.aspath_seen      = n_aspath;
                res.community_seen   = n_comm;
            end

            // A section end clears everything; an error alone waits for it.
            if (i_item.last) begin
                n_phase  = PH_FLAG;
                n_ext    = 1'b0;
                n_cls    = 1'b0;
                n_type   = 8'd0;
                n_len    = 16'd0;
                n_cnt    = 16'd0;
                n_shift  = 32'd0;
                n_origin = 2'd0;
                n_nhop   = 32'd0;
                n_med    = 32'd0;
                n_lpref  = 32'd0;
                n_atomic = 1'b0;
                n_aspath = 1'b0;
                n_comm   = 1'b0;
            end else if (err != bgpap_pkg::STAT_OK) begin
                n_phase = PH_DRAIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FLAG;
            r_ext       <= 1'b0;
            r_cls       <= 1'b0;
            r_type      <= 8'd0;
            r_len       <= 16'd0;
            r_cnt       <= 16'd0;
            r_shift     <= 32'd0;
            r_origin    <= 2'd0;
            r_nhop      <= 32'd0;
            r_med       <= 32'd0;
            r_lpref     <= 32'd0;
            r_atomic    <= 1'b0;
            r_aspath    <= 1'b0;
            r_comm      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_ext    <= n_ext;
            r_cls    <= n_cls;
            r_type   <= n_type;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_shift  <= n_shift;
            r_origin <= n_origin;
            r_nhop   <= n_nhop;
            r_med    <= n_med;
            r_lpref  <= n_lpref;
            r_atomic <= n_atomic;
            r_aspath <= n_aspath;
            r_comm   <= n_comm;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_res <= res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bgp_path_attribute_parser_top.sv
// Top level of the BGP path-attribute parser: front end, queue and back end.
// Depends on bgpap_pkg, bgpap_front, bgpap_queue and bgpap_back.
`default_nettype none

// The block reads the path-attribute section of a BGP UPDATE one byte per
// request and returns one result request per section: on the byte marked as
// last, or at the first malformed attribute, whichever comes first. Bytes
// after an error are consumed silently until the last byte of that section.
// A byte is accepted on every cycle in which o_in_ready is high, so the
// sustained rate is one byte per clock. The front end classifies each byte and
// writes it into a small register queue of QUEUE_DEPTH entries; the back end
// drains that queue at one byte per cycle through the attribute state machine
// and loads the result into an output register. With an empty queue and a
// free output, the deciding byte goes through the queue into the back end,
// whose output register then raises o_out_valid. While a result waits for
// i_out_ready the back end holds, and the queue absorbs up to QUEUE_DEPTH
// further bytes before o_in_ready drops. Captured values (next hop, MED,
// local preference) are big-endian and are updated only once all four of
// their bytes have arrived; a local preference of another length is cleared.
module bgp_path_attribute_parser_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_status,
    output logic [1:0]       o_origin_code,
    output logic [31:0]      o_next_hop_addr,
    output logic [31:0]      o_med_value,
    output logic [31:0]      o_local_pref_value,
    output logic             o_atomic_seen,
    output logic             o_aspath_seen,
    output logic             o_community_seen
);

    bgpap_pkg::t_item   front_item;
    bgpap_pkg::t_item   queue_item;
    bgpap_pkg::t_result res;
    logic               push;
    logic               pop;
    logic               queue_not_full;
    logic               queue_not_empty;

    // Classify the byte so that the back end only selects precomputed tests.
    bgpap_front u_front (
        .i_data_byte_valid (i_in_valid),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .i_queue_ready     (queue_not_full),
        .o_item            (front_item),
        .o_push            (push),
        .o_in_ready        (o_in_ready)
    );

    // The queue lets input keep flowing while a result is held at the output.
    bgpap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (front_item),
        .o_not_full  (queue_not_full),
        .i_pop       (pop),
        .o_not_empty (queue_not_empty),
        .o_item      (queue_item)
    );

    // The back end parses the attributes and owns the result register.
    bgpap_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (queue_not_empty),
        .i_item       (queue_item),
        .o_pop        (pop),
        .o_res_valid  (o_out_valid),
        .i_res_ready  (i_out_ready),
        .o_res        (res)
    );

    assign o_status           = res.status;
    assign o_origin_code      = res.origin_code;
    assign o_next_hop_addr    = res.next_hop_addr;
    assign o_med_value        = res.med_value;
    assign o_local_pref_value = res.local_pref_value;
    assign o_atomic_seen      = res.atomic_seen;
    assign o_aspath_seen      = res.aspath_seen;
    assign o_community_seen   = res.community_seen;

endmodule

`default_nettype wire

>>> rtl/bgpap_checker.sv
// Port-level checker for the path-attribute parser and its bind to the top.
// Depends on bgpap_pkg and on the assertion macros in the shared header.
`default_nettype none

`include "bgp_path_attribute_parser_top_assert.svh"

module bgpap_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [7:0]  i_data_byte,
    input wire logic        i_last_byte,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  o_status,
    input wire logic [1:0]  o_origin_code,
    input wire logic [31:0] o_next_hop_addr,
    input wire logic [31:0] o_med_value,
    input wire logic [31:0] o_local_pref_value,
    input wire logic        o_atomic_seen,
    input wire logic        o_aspath_seen,
    input wire logic        o_community_seen
);

    // Status codes above the truncated code are never produced.
    `BGPAP_ASSERT_SAME(a_status_range, i_clk, i_rst_n, o_out_valid, o_status <= bgpap_pkg::STAT_TRUNCATED, "status code out of range")

    // Only checked origin values are ever captured.
    `BGPAP_ASSERT_SAME(a_origin_range, i_clk, i_rst_n, o_out_valid, o_origin_code != 2'd3, "origin code out of range")

    // A duplicate AS path can only be reported once an AS path was recorded.
    `BGPAP_ASSERT_SAME(a_dup_aspath, i_clk, i_rst_n, o_out_valid && o_status == bgpap_pkg::STAT_DUP_ASPATH, o_aspath_seen, "duplicate AS path without AS path")

    // A stalled result keeps its status and values.
    `BGPAP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_next_hop_addr) && $stable(o_med_value) && $stable(o_local_pref_value), "stalled result changed")

endmodule

bind bgp_path_attribute_parser_top bgpap_checker u_bgpap_checker (.*);

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for bgp_path_attribute_parser_top: byte requests in, section results out.
// Depends on bgpap_pkg and on the RTL of the block; a built-in predictor produces the expected results.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bgpap_pkg::*;

    // A section yields far fewer results than bytes, but no single cycle should
    // go this long without either a byte request or a result request moving.
    localparam int STALL_LIMIT = 1000;
    // The random part stops once about this many bytes have been sent.
    localparam int RANDOM_BYTES = 550;
    // Cycles allowed for a stray result to show up after the last expected one.
    localparam int DRAIN_CYCLES = 20;

    // Where the predictor stands inside the current attribute.
    typedef enum logic [2:0] {
        AP_FLAG,
        AP_TYPE,
        AP_LEN_HI,
        AP_LEN_LO,
        AP_VALUE,
        AP_DRAIN
    } t_attr_phase;

    // Stall patterns of the result receiver.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_LIGHT
    } t_rx_mode;

    // Kinds of damage done to one attribute of a random section.
    typedef enum logic [1:0] {
        DMG_NONE,
        DMG_FLAGS,
        DMG_LENGTH,
        DMG_VALUE
    } t_damage;

    // One row of the directed table. A pinned row must produce a result with the
    // given status; all other fields still come from the predictor.
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         pinned;
        t_status    want;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_status;
    logic [1:0]  o_origin_code;
    logic [31:0] o_next_hop_addr;
    logic [31:0] o_med_value;
    logic [31:0] o_local_pref_value;
    logic        o_atomic_seen;
    logic        o_aspath_seen;
    logic        o_community_seen;

    bgp_path_attribute_parser_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_origin_code      (o_origin_code),
        .o_next_hop_addr    (o_next_hop_addr),
        .o_med_value        (o_med_value),
        .o_local_pref_value (o_local_pref_value),
        .o_atomic_seen      (o_atomic_seen),
        .o_aspath_seen      (o_aspath_seen),
        .o_community_seen   (o_community_seen)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Attribute parser predictor. It tracks the section exactly as the block
    // should: header bytes, value bytes, captured values and seen flags.
    // ------------------------------------------------------------------
    t_attr_phase attr_phase;
    logic [7:0]  attr_flags;
    logic [7:0]  attr_type;
    logic [15:0] attr_len;
    logic [15:0] value_bytes;
    logic [31:0] value_word;
    logic [1:0]  cap_origin;
    logic [31:0] cap_next_hop;
    logic [31:0] cap_med;
    logic [31:0] cap_local_pref;
    logic        seen_atomic;
    logic        seen_aspath;
    logic        seen_community;

    // Results still owed by the block, oldest first.
    t_result     results_due[$];
    int          mismatches = 0;

    function automatic void clear_section();
        attr_phase     = AP_FLAG;
        attr_flags     = '0;
        attr_type      = '0;
        attr_len       = '0;
        value_bytes    = '0;
        value_word     = '0;
        cap_origin     = '0;
        cap_next_hop   = '0;
        cap_med        = '0;
        cap_local_pref = '0;
        seen_atomic    = 1'b0;
        seen_aspath    = 1'b0;
        seen_community = 1'b0;
    endfunction

    // Header checks, made once the last length byte is in. Also records the
    // presence flags that depend only on the header.
    function automatic t_status check_attr_header();
        case (attr_type)
            TYPE_ORIGIN: begin
                if ((attr_flags & FLAG_CLASS_MASK) != FLAG_TRANSITIVE) return STAT_ORIGIN_FLAG;
                if (attr_len != LEN_ORIGIN) return STAT_ORIGIN_LEN;
            end
            TYPE_ASPATH: begin
                if (seen_aspath) return STAT_DUP_ASPATH;
                seen_aspath = 1'b1;
            end
            TYPE_NEXTHOP: begin
                if (attr_len != LEN_WORD) return STAT_NEXTHOP_LEN;
            end
            TYPE_MED: begin
                if (attr_len != LEN_WORD) return STAT_MED_LEN;
            end
            TYPE_LPREF: begin
                // A local preference of the wrong size wipes the old one.
                if (attr_len != LEN_WORD) cap_local_pref = '0;
            end
            TYPE_ATOMIC: begin
                if (attr_len != 16'd0) return STAT_ATOMIC_LEN;
                seen_atomic = 1'b1;
            end
            TYPE_COMMUNITY: begin
                // An empty communities attribute clears the flag again.
                seen_community = (attr_len != 16'd0);
            end
            default: ;
        endcase
        return STAT_OK;
    endfunction

    // Advances the predictor by one accepted byte. Sets produced when this
    // byte closes the section or hits the first error of the section.
    function automatic void parse_byte(input logic [7:0] b, input logic lst,
                                       output bit produced, output t_result res);
        t_status err;
        err = STAT_OK;
        produced = 1'b0;
        res = '0;
        case (attr_phase)
            AP_FLAG: begin
                attr_flags = b;
                attr_phase = AP_TYPE;
            end
            AP_TYPE: begin
                attr_type = b;
                attr_len = '0;
                attr_phase = ((attr_flags & FLAG_EXTLEN) != 0) ? AP_LEN_HI : AP_LEN_LO;
            end
            AP_LEN_HI: begin
                attr_len = {b, 8'h00};
                attr_phase = AP_LEN_LO;
            end
            AP_LEN_LO: begin
                attr_len = attr_len | {8'h00, b};
                value_bytes = '0;
                value_word = '0;
                err = check_attr_header();
                if (err == STAT_OK) attr_phase = (attr_len != 16'd0) ? AP_VALUE : AP_FLAG;
            end
            AP_VALUE: begin
                value_word = {value_word[23:0], b};
                value_bytes = value_bytes + 16'd1;
                if (attr_type == TYPE_ORIGIN) begin
                    if (b > ORIGIN_MAX) err = STAT_ORIGIN_VAL;
                    else cap_origin = b[1:0];
                end
                // Captured words are only stored once complete.
                if (err == STAT_OK && value_bytes == attr_len) begin
                    if (attr_type == TYPE_NEXTHOP) cap_next_hop = value_word;
                    else if (attr_type == TYPE_MED) cap_med = value_word;
                    else if (attr_type == TYPE_LPREF && attr_len == LEN_WORD)
                        cap_local_pref = value_word;
                    attr_phase = AP_FLAG;
                end
            end
            default: begin
                // After an error everything up to the last byte is swallowed.
                if (lst) clear_section();
                return;
            end
        endcase

        if (err == STAT_OK && !lst) return;

        produced = 1'b1;
        if (err != STAT_OK) res.status = err;
        else if (attr_phase == AP_FLAG) res.status = STAT_OK;
        else res.status = STAT_TRUNCATED;
        res.origin_code      = cap_origin;
        res.next_hop_addr    = cap_next_hop;
        res.med_value        = cap_med;
        res.local_pref_value = cap_local_pref;
        res.atomic_seen      = seen_atomic;
        res.aspath_seen      = seen_aspath;
        res.community_seen   = seen_community;

        if (lst) clear_section();
        else attr_phase = AP_DRAIN;
    endfunction

    // ------------------------------------------------------------------
    // Byte sender. Requests go out in bursts of random length; between bursts
    // the sender may idle unless the current section is a calm one.
    // Valid is only lowered when a real gap follows, so it never sees two
    // nonblocking writes in one time step.
    // ------------------------------------------------------------------
    int burst_left = 0;
    bit calm = 1'b0;

    task automatic send_byte(input logic [7:0] b, input logic lst,
                             output bit produced, output t_result res);
        int gap;
        if (burst_left == 0) begin
            gap = calm ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= lst;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        parse_byte(b, lst, produced, res);
    endtask

    // ------------------------------------------------------------------
    // Random section builder. Most sections are well formed so that the
    // parser walks deep into the attribute list; some carry one damaged
    // attribute, some are cut short, some have a huge extended length, and
    // the rest are raw noise.
    // ------------------------------------------------------------------
    logic [7:0] section_bytes[$];
    bit         aspath_used;

    function automatic void add_attr(input t_damage dmg);
        logic [7:0]  flags;
        logic [7:0]  kind;
        logic [15:0] len;
        int          pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: kind = TYPE_ORIGIN;
            1: kind = TYPE_ASPATH;
            2: kind = TYPE_NEXTHOP;
            3: kind = TYPE_MED;
            4: kind = TYPE_LPREF;
            5: kind = TYPE_ATOMIC;
            6: kind = TYPE_COMMUNITY;
            default: kind = 8'($urandom_range(9, 255));
        endcase
        // A second AS path is only sent on purpose, as damage.
        if (kind == TYPE_ASPATH && aspath_used && dmg == DMG_NONE) kind = TYPE_COMMUNITY;
        if (kind == TYPE_ASPATH) aspath_used = 1'b1;

        flags = 8'($urandom);
        if (kind == TYPE_ORIGIN && dmg != DMG_FLAGS)
            flags = (flags & ~FLAG_CLASS_MASK) | FLAG_TRANSITIVE;

        case (kind)
            TYPE_ORIGIN:    len = LEN_ORIGIN;
            TYPE_NEXTHOP,
            TYPE_MED:       len = LEN_WORD;
            TYPE_LPREF:     len = ($urandom_range(0, 3) != 0) ? LEN_WORD
                                                              : 16'($urandom_range(0, 6));
            TYPE_ATOMIC:    len = 16'd0;
            TYPE_COMMUNITY: len = 16'(4 * $urandom_range(0, 3));
            default:        len = 16'($urandom_range(0, 8));
        endcase
        if (dmg == DMG_LENGTH) len = 16'($urandom_range(0, 6));

        section_bytes.push_back(flags);
        section_bytes.push_back(kind);
        if ((flags & FLAG_EXTLEN) != 0) section_bytes.push_back(len[15:8]);
        section_bytes.push_back(len[7:0]);
        for (int i = 0; i < int'(len); i++) begin
            if (kind == TYPE_ORIGIN && dmg != DMG_VALUE)
                section_bytes.push_back(8'($urandom_range(0, 2)));
            else
                section_bytes.push_back(8'($urandom));
        end
    endfunction

    task automatic run_random_sections();
        int       random_sent;
        int       shape;
        int       n_attr;
        int       bad_attr;
        int       keep;
        bit       produced;
        t_result  res;
        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            shape = $urandom_range(0, 19);
            calm = ($urandom_range(0, 3) == 0);
            aspath_used = 1'b0;
            section_bytes.delete();
            if (shape >= 18) begin
                // Raw noise of any content.
                repeat ($urandom_range(1, 12)) section_bytes.push_back(8'($urandom));
            end else if (shape == 17) begin
                // Extended length far beyond the section; always ends truncated
                // unless the header itself is rejected.
                section_bytes.push_back(8'($urandom) | FLAG_EXTLEN);
                section_bytes.push_back(8'($urandom));
                section_bytes.push_back(8'($urandom_range(1, 255)));
                section_bytes.push_back(8'($urandom));
                repeat ($urandom_range(0, 6)) section_bytes.push_back(8'($urandom));
            end else begin
                n_attr = $urandom_range(1, 4);
                bad_attr = (shape >= 14) ? $urandom_range(0, n_attr - 1) : -1;
                for (int a = 0; a < n_attr; a++) begin
                    if (a == bad_attr) add_attr(t_damage'($urandom_range(1, 3)));
                    else add_attr(DMG_NONE);
                end
                // Now and then the section ends in the middle of an attribute.
                if ($urandom_range(0, 7) == 0) begin
                    keep = $urandom_range(1, section_bytes.size());
                    while (section_bytes.size() > keep) void'(section_bytes.pop_back());
                end
            end
            foreach (section_bytes[i]) begin
                send_byte(section_bytes[i], (i == section_bytes.size() - 1), produced, res);
                if (produced) results_due.push_back(res);
            end
            random_sent += section_bytes.size();
        end
    endtask

    // ------------------------------------------------------------------
    // Directed sections. The pinned statuses are the obvious outcome of each
    // section: a clean origin, a bad origin value followed by swallowed bytes,
    // a next hop of the wrong size behind an extended length, a zero-length
    // atomic aggregate followed by a cut-off communities header, an origin
    // with the optional bit set, and a section that is a lone flag byte.
    // ------------------------------------------------------------------
    localparam int PLAN_LEN = 24;
    t_plan_row plan [PLAN_LEN] = '{
        '{8'h40, 1'b0, 1'b0, STAT_OK},
        '{8'h01, 1'b0, 1'b0, STAT_OK},
        '{8'h01, 1'b0, 1'b0, STAT_OK},
        '{8'h02, 1'b1, 1'b1, STAT_OK},
        '{8'h40, 1'b0, 1'b0, STAT_OK},
        '{8'h01, 1'b0, 1'b0, STAT_OK},
        '{8'h01, 1'b0, 1'b0, STAT_OK},
        '{8'hFF, 1'b0, 1'b1, STAT_ORIGIN_VAL},
        '{8'hAA, 1'b1, 1'b0, STAT_OK},
        '{8'hFF, 1'b0, 1'b0, STAT_OK},
        '{8'h03, 1'b0, 1'b0, STAT_OK},
        '{8'h00, 1'b0, 1'b0, STAT_OK},
        '{8'h05, 1'b0, 1'b1, STAT_NEXTHOP_LEN},
        '{8'h00, 1'b1, 1'b0, STAT_OK},
        '{8'h40, 1'b0, 1'b0, STAT_OK},
        '{8'h06, 1'b0, 1'b0, STAT_OK},
        '{8'h00, 1'b0, 1'b0, STAT_OK},
        '{8'hC0, 1'b0, 1'b0, STAT_OK},
        '{8'h08, 1'b1, 1'b1, STAT_TRUNCATED},
        '{8'h80, 1'b0, 1'b0, STAT_OK},
        '{8'h01, 1'b0, 1'b0, STAT_OK},
        '{8'h01, 1'b0, 1'b1, STAT_ORIGIN_FLAG},
        '{8'h00, 1'b1, 1'b0, STAT_OK},
        '{8'hFF, 1'b1, 1'b1, STAT_TRUNCATED}
    };

    initial begin
        bit      produced;
        t_result res;
        clear_section();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table first; a pinned row overrides only the status.
        for (int r = 0; r < PLAN_LEN; r++) begin
            send_byte(plan[r].data, plan[r].last, produced, res);
            if (plan[r].pinned) begin
                if (!produced) begin
                    $error("directed row %0d: predictor closed no section here", r);
                    mismatches++;
                end else begin
                    res.status = plan[r].want;
                end
            end
            if (produced) results_due.push_back(res);
        end

        run_random_sections();
        i_in_valid <= 1'b0;

        // Wait out every owed result, then give a stray one time to appear.
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result receiver. The stall pattern is redrawn when rx_cycle[5:0] is zero:
    // always ready, coin flips, ready when rx_cycle[2:0] is zero, light stalls.
    // ------------------------------------------------------------------
    t_rx_mode    rx_mode = RX_FREE;
    logic [15:0] rx_cycle = '0;

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 16'd1;
        if (rx_cycle[5:0] == 6'd0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_FREE:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= (rx_cycle[2:0] == 3'd0);
            default:   i_out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result request is compared field by
    // field with the oldest owed result.
    // ------------------------------------------------------------------
    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want === got) return 0;
        $error("%s: expected %0h, got %0h", name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                $error("result with status %0d arrived with nothing owed", o_status);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                mismatches += field_differs("status", 32'(want.status), 32'(o_status));
                mismatches += field_differs("origin_code", 32'(want.origin_code),
                                            32'(o_origin_code));
                mismatches += field_differs("next_hop_addr", want.next_hop_addr,
                                            o_next_hop_addr);
                mismatches += field_differs("med_value", want.med_value, o_med_value);
                mismatches += field_differs("local_pref_value", want.local_pref_value,
                                            o_local_pref_value);
                mismatches += field_differs("atomic_seen", 32'(want.atomic_seen),
                                            32'(o_atomic_seen));
                mismatches += field_differs("aspath_seen", 32'(want.aspath_seen),
                                            32'(o_aspath_seen));
                mismatches += field_differs("community_seen", 32'(want.community_seen),
                                            32'(o_community_seen));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if neither channel moves for too long.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

>>> files.f
+incdir+rtl
rtl/bgpap_pkg.sv
rtl/bgpap_front.sv
rtl/bgpap_queue.sv
rtl/bgpap_back.sv
rtl/bgp_path_attribute_parser_top.sv
rtl/bgpap_checker.sv
dv/tb.sv
